// File: rtl/barometric_compensation_macros.svh
// Assertion macros shared by the barometric compensation RTL.
`ifndef BAROMETRIC_COMPENSATION_MACROS_SVH
`define BAROMETRIC_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bcmp_pkg.sv
// Shared types, constants and helpers of the barometric compensation block.
package bcmp_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TEMP_CAL   = 2'd0;
  localparam cfg_idx_t CFG_PRESS_LOW  = 2'd1;
  localparam cfg_idx_t CFG_PRESS_HIGH = 2'd2;
  localparam cfg_idx_t CFG_PRESS_LAST = 2'd3;

  // Quotient width and divisor magnitude width of the pressure division.
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 31;
  localparam int DIV_STEPS = NUM_W;

  // Data that rides along with an item through the divider.
  typedef struct packed {
    logic signed [15:0] temp;
    logic               neg;
    logic               invalid;
  } bcmp_side_t;

  // Partial products of a 64 x 64 multiply that keeps the low 64 bits.
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] mid_a;
    logic [31:0] mid_b;
  } bcmp_part_t;

  function automatic bcmp_part_t mul_split(input logic [63:0] x, input logic [63:0] y);
    bcmp_part_t p;
    logic [63:0] pa;
    logic [63:0] pb;
    p.lo  = {32'b0, x[31:0]} * {32'b0, y[31:0]};
    pa    = {32'b0, x[31:0]} * {32'b0, y[63:32]};
    pb    = {32'b0, x[63:32]} * {32'b0, y[31:0]};
    p.mid_a = pa[31:0];
    p.mid_b = pb[31:0];
    return p;
  endfunction

  function automatic logic [63:0] mul_join(input bcmp_part_t p);
    logic [31:0] mid;
    mid = p.mid_a + p.mid_b;
    return p.lo + {mid, 32'b0};
  endfunction

endpackage

// File: rtl/bcmp_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, side data carried along.
`include "barometric_compensation_macros.svh"

module bcmp_div_pipe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [bcmp_pkg::NUM_W-1:0] in_num,
  input  logic [bcmp_pkg::DEN_W-1:0] in_den,
  input  bcmp_pkg::bcmp_side_t       in_side,
  output logic                       out_valid,
  output logic [bcmp_pkg::NUM_W-1:0] out_quot,
  output bcmp_pkg::bcmp_side_t       out_side
);
  import bcmp_pkg::*;

  localparam int LAST = DIV_STEPS - 1;

  logic             v_r    [DIV_STEPS];
  logic [NUM_W-1:0] n_r    [DIV_STEPS];
  logic [DEN_W-1:0] rem_r  [DIV_STEPS];
  logic [DEN_W-1:0] ud_r   [DIV_STEPS];
  bcmp_side_t       side_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic             v_in;
    logic [NUM_W-1:0] n_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] ud_in;
    bcmp_side_t       side_in;
    logic [DEN_W:0]   r2;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign n_in    = in_num;
      assign rem_in  = '0;
      assign ud_in   = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign ud_in   = ud_r[k-1];
      assign side_in = side_r[k-1];
    end

    // The numerator register shifts left; quotient bits fill in from the bottom.
    assign r2   = {rem_in, n_in[NUM_W-1]};
    assign diff = r2 - {1'b0, ud_in};
    assign ge   = (r2 >= {1'b0, ud_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      n_r[k]    <= {n_in[NUM_W-2:0], ge};
      rem_r[k]  <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
      ud_r[k]   <= ud_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[LAST];
  assign out_quot  = n_r[LAST];
  assign out_side  = side_r[LAST];

  `BCMP_ASSERT_NXT(a_valid_moves, clk, rst_n, v_r[0], v_r[1], "divider valid bit lost")
  `BCMP_ASSERT_IMP(a_rem_bound, clk, rst_n, v_r[LAST] && (ud_r[LAST] != '0), rem_r[LAST] < ud_r[LAST], "final remainder not below divisor")
  `BCMP_ASSERT_NXT(a_side_moves, clk, rst_n, v_r[0], side_r[1] == $past(side_r[0]), "side data not carried")

endmodule

// File: rtl/barometric_compensation.sv
// Top level of the barometric compensation pipeline.
//
// Usage:
//   Input: an item is taken at a rising edge where start is high and busy is low.
//   busy never rises, so one raw temperature/pressure pair can be taken every cycle.
//   Results: out_valid is high for one cycle with the compensated temperature in
//   0.01 degC, the pressure as unsigned Q24.8 Pa and the invalid-calibration flag.
//   A transfer completes at the edge that ends the cycle in which out_valid is
//   high. Throughput is one item per cycle. The pipeline is the 64-stage pressure
//   divider (one quotient bit per stage) plus twelve stages before it and seven
//   after it; the first stage loads at the edge that takes start.
//   The receiver cannot stall; results are shown once and never held.
//   Configuration: cfg_ready is always high; a write lands when cfg_valid is high.
//   Write the calibration words only while no item is in flight.
//   Reset (synchronous, active low) clears all calibration words to zero and
//   empties the pipeline; items in flight are dropped.
//   A zero pressure divisor gives pressure zero and sets the invalid flag.
`include "barometric_compensation_macros.svh"

module barometric_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  output logic signed [15:0] out_temperature_centi,
  output logic [31:0]        out_pressure_q24_8,
  output logic               out_calibration_invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  bcmp_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_data
);
  import bcmp_pkg::*;

  // Smallest fine temperature whose centi value exceeds the signed 16-bit range.
  localparam int FINE_SAT_HI = 1677696;

  logic [47:0] temp_cal_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_last_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r   <= '0;
      press_low_r  <= '0;
      press_high_r <= '0;
      press_last_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TEMP_CAL:   temp_cal_r   <= cfg_data[47:0];
        CFG_PRESS_LOW:  press_low_r  <= cfg_data;
        CFG_PRESS_HIGH: press_high_r <= cfg_data;
        CFG_PRESS_LAST: press_last_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1u;
  logic signed [15:0] t2s, t3s;
  logic [15:0]        p1u;
  logic signed [15:0] p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;

  assign t1u = temp_cal_r[15:0];
  assign t2s = temp_cal_r[31:16];
  assign t3s = temp_cal_r[47:32];
  assign p1u = press_low_r[15:0];
  assign p2s = press_low_r[31:16];
  assign p3s = press_low_r[47:32];
  assign p4s = press_low_r[63:48];
  assign p5s = press_high_r[15:0];
  assign p6s = press_high_r[31:16];
  assign p7s = press_high_r[47:32];
  assign p8s = press_high_r[63:48];
  assign p9s = press_last_r;

  // Front pipeline valid bits: stages 0 to 11.
  logic [11:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[10:0], start};
    end
  end

  logic [19:0]        adc_t0_r;
  logic [19:0]        adc_p_r [8];
  logic signed [34:0] ta1_r;
  logic signed [35:0] dd1_r;
  logic signed [23:0] ta2_r;
  logic signed [39:0] tb2_r;
  logic signed [26:0] fine3_r;
  logic signed [15:0] temp_r [4:11];
  logic signed [27:0] pa4_r;
  logic signed [55:0] aa5_r;
  logic signed [43:0] ap5_5_r, ap2_5_r, ap5_6_r, ap2_6_r;
  logic signed [63:0] m6_r, m3_r;
  logic signed [63:0] b7_r, av7_r;
  logic [47:0]        plo8_r;
  logic [31:0]        phi8_r;
  logic [63:0]        nm8_r;
  logic signed [30:0] den9_r, den10_r;
  logic [43:0]        nlo9_r;
  logic [31:0]        nhi9_r;
  logic [63:0]        num10_r;
  logic               inv10_r;
  logic [63:0]        un11_r;
  logic [DEN_W-1:0]   ud11_r;
  bcmp_side_t         side11_r;

  logic signed [18:0] dx;
  logic signed [17:0] dt;
  logic signed [23:0] dd_sh;
  logic signed [29:0] t5;
  logic signed [21:0] ts;
  logic signed [15:0] temp_sat;
  logic [20:0]        pdiff;
  logic [47:0]        phi_full;
  logic [63:0]        psum;
  logic [43:0]        nhi_full;

  always_comb begin
    dx    = $signed({2'b00, adc_t0_r[19:3]}) - $signed({2'b00, t1u, 1'b0});
    dt    = $signed({2'b00, adc_t0_r[19:4]}) - $signed({2'b00, t1u});
    dd_sh = 24'(dd1_r >>> 12);
    t5    = (30'(fine3_r) * 30'sd5) + 30'sd128;
    ts    = 22'(t5 >>> 8);
    if (ts > 22'sd32767) begin
      temp_sat = 16'sh7fff;
    end else if (ts < -22'sd32768) begin
      temp_sat = -16'sh8000;
    end else begin
      temp_sat = ts[15:0];
    end
    pdiff    = 21'h100000 - {1'b0, adc_p_r[7]};
    phi_full = av7_r[63:32] * p1u;
    psum     = {16'b0, plo8_r} + {phi8_r, 32'b0};
    nhi_full = nm8_r[63:32] * 12'd3125;
  end

  always_ff @(posedge clk) begin
    adc_t0_r   <= in_raw_temperature;
    adc_p_r[0] <= in_raw_pressure;
    for (int k = 1; k < 8; k++) begin
      adc_p_r[k] <= adc_p_r[k-1];
    end
    // Temperature.
    ta1_r   <= dx * t2s;
    dd1_r   <= dt * dt;
    ta2_r   <= 24'(ta1_r >>> 11);
    tb2_r   <= dd_sh * t3s;
    fine3_r <= 27'(ta2_r) + 27'(tb2_r >>> 14);
    temp_r[4] <= temp_sat;
    for (int k = 5; k < 12; k++) begin
      temp_r[k] <= temp_r[k-1];
    end
    // Pressure divisor and numerator; all sums wrap at 64 bits.
    pa4_r   <= 28'(fine3_r) - 28'sd128000;
    aa5_r   <= pa4_r * pa4_r;
    ap5_5_r <= pa4_r * p5s;
    ap2_5_r <= pa4_r * p2s;
    m6_r    <= 64'(aa5_r) * 64'(p6s);
    m3_r    <= 64'(aa5_r) * 64'(p3s);
    ap5_6_r <= ap5_5_r;
    ap2_6_r <= ap2_5_r;
    b7_r    <= m6_r + (64'(ap5_6_r) <<< 17) + (64'(p4s) <<< 35);
    av7_r   <= (m3_r >>> 8) + (64'(ap2_6_r) <<< 12) + 64'sh0000_8000_0000_0000;
    plo8_r  <= av7_r[31:0] * p1u;
    phi8_r  <= phi_full[31:0];
    nm8_r   <= ({43'b0, pdiff} << 31) - $unsigned(b7_r);
    den9_r  <= $signed(psum[63:33]);
    nlo9_r  <= nm8_r[31:0] * 12'd3125;
    nhi9_r  <= nhi_full[31:0];
    num10_r <= {20'b0, nlo9_r} + {nhi9_r, 32'b0};
    den10_r <= den9_r;
    inv10_r <= (den9_r == '0);
    un11_r  <= num10_r[63] ? (64'd0 - num10_r) : num10_r;
    ud11_r  <= den10_r[30] ? (31'd0 - $unsigned(den10_r)) : $unsigned(den10_r);
    side11_r.temp    <= temp_r[10];
    side11_r.neg     <= num10_r[63] ^ den10_r[30];
    side11_r.invalid <= inv10_r;
  end

  logic             div_valid;
  logic [NUM_W-1:0] div_quot;
  bcmp_side_t       div_side;

  bcmp_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[11]),
    .in_num    (un11_r),
    .in_den    (ud11_r),
    .in_side   (side11_r),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // Back pipeline: sign fix, three 64-bit wrapping products, final sum.
  logic [6:0]         pv_r;
  bcmp_side_t         ps_r [7];
  logic signed [63:0] q_r, q1_r, q2_r, q3_r, q4_r;
  logic signed [63:0] s1_r, s2_r;
  bcmp_part_t         pa_r, pb_r, pc_r;
  logic signed [63:0] m1_r, bq_r, b3_r, b4_r, a4_r, sum_r;
  logic [31:0]        press_r;
  logic signed [63:0] s0;
  logic signed [63:0] press_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {pv_r[5:0], div_valid};
    end
  end

  always_comb begin
    s0         = q_r >>> 13;
    press_full = (sum_r >>> 8) + (64'(p7s) <<< 4);
  end

  always_ff @(posedge clk) begin
    ps_r[0] <= div_side;
    for (int k = 1; k < 7; k++) begin
      ps_r[k] <= ps_r[k-1];
    end
    q_r   <= div_side.neg ? $signed(64'd0 - div_quot) : $signed(div_quot);
    pa_r  <= mul_split(64'(p9s), s0);
    pb_r  <= mul_split(64'(p8s), q_r);
    q1_r  <= q_r;
    s1_r  <= s0;
    m1_r  <= mul_join(pa_r);
    bq_r  <= mul_join(pb_r);
    q2_r  <= q1_r;
    s2_r  <= s1_r;
    pc_r  <= mul_split(m1_r, s2_r);
    b3_r  <= bq_r >>> 19;
    q3_r  <= q2_r;
    a4_r  <= $signed(mul_join(pc_r)) >>> 25;
    b4_r  <= b3_r;
    q4_r  <= q3_r;
    sum_r <= q4_r + a4_r + b4_r;
    press_r <= ps_r[5].invalid ? 32'd0 : press_full[31:0];
  end

  assign out_valid               = pv_r[6];
  assign out_temperature_centi   = ps_r[6].temp;
  assign out_calibration_invalid = ps_r[6].invalid;
  assign out_pressure_q24_8      = press_r;

  `BCMP_ASSERT_NXT(a_start_taken, clk, rst_n, start, v_r[0], "accepted item did not enter the pipeline")
  `BCMP_ASSERT_NXT(a_temp_sat, clk, rst_n, v_r[3] && (fine3_r >= FINE_SAT_HI), temp_r[4] == 16'sh7fff, "high temperature not saturated")
  `BCMP_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid && out_calibration_invalid, out_pressure_q24_8 == '0, "invalid calibration with nonzero pressure")

endmodule
